// File: rtl/core/gtl_pkg.sv
// shared types, token kinds, error codes and byte classes for the query lexer
// no dependencies
package gtl_pkg;

    localparam int GTL_POSITION_BITS = 16;
    localparam int GTL_QUEUE_DEPTH   = 4;

    localparam logic RT_TOKEN = 1'b0;
    localparam logic RT_VALUE = 1'b1;

    localparam logic [4:0] K_EOF       = 5'd0;
    localparam logic [4:0] K_BANG      = 5'd1;
    localparam logic [4:0] K_DOLLAR    = 5'd2;
    localparam logic [4:0] K_AMP       = 5'd3;
    localparam logic [4:0] K_PAREN_L   = 5'd4;
    localparam logic [4:0] K_PAREN_R   = 5'd5;
    localparam logic [4:0] K_SPREAD    = 5'd6;
    localparam logic [4:0] K_COLON     = 5'd7;
    localparam logic [4:0] K_EQUALS    = 5'd8;
    localparam logic [4:0] K_AT        = 5'd9;
    localparam logic [4:0] K_BRACKET_L = 5'd10;
    localparam logic [4:0] K_BRACKET_R = 5'd11;
    localparam logic [4:0] K_BRACE_L   = 5'd12;
    localparam logic [4:0] K_PIPE      = 5'd13;
    localparam logic [4:0] K_BRACE_R   = 5'd14;
    localparam logic [4:0] K_NAME      = 5'd15;
    localparam logic [4:0] K_INT       = 5'd16;
    localparam logic [4:0] K_FLOAT     = 5'd17;
    localparam logic [4:0] K_STRING    = 5'd18;
    localparam logic [4:0] K_COMMENT   = 5'd19;

    localparam logic [2:0] E_NONE         = 3'd0;
    localparam logic [2:0] E_CONTROL      = 3'd1;
    localparam logic [2:0] E_UNEXPECTED   = 3'd2;
    localparam logic [2:0] E_LEADING_ZERO = 3'd3;
    localparam logic [2:0] E_EXP_DIGIT    = 3'd4;
    localparam logic [2:0] E_UNTERMINATED = 3'd5;
    localparam logic [2:0] E_BAD_CHAR     = 3'd6;
    localparam logic [2:0] E_BAD_ESCAPE   = 3'd7;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_NINE   = 8'd57;
    localparam logic [7:0] CH_LOW_E  = 8'h65;
    localparam logic [7:0] CH_UP_E   = 8'h45;

    typedef struct packed {
        logic       result_type;
        logic [4:0] token_kind;
        logic [15:0] start_pos;
        logic [15:0] end_pos;
        logic [7:0] value_byte;
        logic [2:0] error_code;
        logic       last_of_run;
    } gtl_result_t;

    // single-byte punctuators, zero when the byte is not one
    function automatic logic [4:0] punct_kind(input logic [7:0] b);
        logic [4:0] k;
        k = K_EOF;
        case (b)
            8'h21:   k = K_BANG;
            8'h24:   k = K_DOLLAR;
            8'h26:   k = K_AMP;
            8'h28:   k = K_PAREN_L;
            8'h29:   k = K_PAREN_R;
            8'h3A:   k = K_COLON;
            8'h3D:   k = K_EQUALS;
            8'h40:   k = K_AT;
            8'h5B:   k = K_BRACKET_L;
            8'h5D:   k = K_BRACKET_R;
            8'h7B:   k = K_BRACE_L;
            8'h7C:   k = K_PIPE;
            8'h7D:   k = K_BRACE_R;
            default: k = K_EOF;
        endcase
        return k;
    endfunction

    // escape decode: bit 8 set when the escape is valid
    function automatic logic [8:0] unescape(input logic [7:0] b);
        logic [8:0] v;
        v = 9'd0;
        case (b)
            8'h22:   v = {1'b1, 8'h22};
            8'h2F:   v = {1'b1, 8'h2F};
            8'h5C:   v = {1'b1, 8'h5C};
            8'h62:   v = {1'b1, 8'd8};
            8'h66:   v = {1'b1, 8'd12};
            8'h6E:   v = {1'b1, 8'd10};
            8'h72:   v = {1'b1, 8'd13};
            8'h74:   v = {1'b1, 8'd9};
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/gtl_core.sv
// lexer mode register, position counters and per-byte next-state logic
// depends on gtl_pkg
module gtl_core
    import gtl_pkg::*;
#(
    parameter int POSITION_BITS = GTL_POSITION_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step_en,
    input  logic [7:0]  data_byte,
    input  logic        end_of_query,
    output gtl_result_t res0,
    output gtl_result_t res1,
    output logic [1:0]  res_count
);

    typedef enum logic [3:0] {
        M_IDLE, M_DOT1, M_DOT2, M_NAME, M_NSIGN, M_NZERO, M_NINT, M_NDOT,
        M_NFRAC, M_NEXP, M_NESIGN, M_NEDIG, M_STR, M_ESC, M_CMT, M_ERR
    } mode_t;

    localparam logic [POSITION_BITS-1:0] PosMax = '1;

    mode_t                    mode_reg, mode_next;
    logic [POSITION_BITS-1:0] tok_start_reg, tok_start_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic                     is_float_reg, is_float_next;

    function automatic logic [POSITION_BITS-1:0] pos_inc(input logic [POSITION_BITS-1:0] p);
        return (p == PosMax) ? p : p + 1'b1;
    endfunction

    function automatic logic [15:0] clip16(input logic [POSITION_BITS-1:0] p);
        logic [31:0] w;
        w = 32'(p);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || (b == 8'h5F);
    endfunction

    function automatic gtl_result_t make_rec(
        input logic                     rtype,
        input logic [4:0]               kind,
        input logic [POSITION_BITS-1:0] s,
        input logic [POSITION_BITS-1:0] e,
        input logic [7:0]               val,
        input logic [2:0]               err
    );
        gtl_result_t r;
        r.result_type = rtype;
        r.token_kind  = kind;
        r.start_pos   = clip16(s);
        r.end_pos     = clip16(e);
        r.value_byte  = val;
        r.error_code  = err;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    // what a byte does when it arrives between tokens
    mode_t       st_mode;
    logic        st_set_ts;
    logic        st_clr_float;
    logic        st_emit;
    gtl_result_t st_rec;
    logic [4:0]  st_kind;

    always_comb
    begin
        st_mode      = M_IDLE;
        st_set_ts    = 1'b0;
        st_clr_float = 1'b0;
        st_emit      = 1'b0;
        st_rec       = '0;
        st_kind      = punct_kind(data_byte);
        if (data_byte == CH_SPACE || data_byte == CH_TAB || data_byte == CH_LF
            || data_byte == CH_CR || data_byte == CH_COMMA)
        begin
            st_mode = M_IDLE;
        end
        else if (data_byte < CH_SPACE)
        begin
            st_mode = M_ERR;
            st_emit = 1'b1;
            st_rec  = make_rec(RT_TOKEN, K_EOF, pos_reg, pos_reg, 8'd0, E_CONTROL);
        end
        else
        begin
            st_set_ts = 1'b1;
            if (st_kind != K_EOF)
            begin
                st_emit = 1'b1;
                st_rec  = make_rec(RT_TOKEN, st_kind, pos_reg, pos_inc(pos_reg), 8'd0, E_NONE);
            end
            else if (data_byte == CH_DOT)
                st_mode = M_DOT1;
            else if (data_byte == CH_HASH)
                st_mode = M_CMT;
            else if (is_alpha(data_byte))
                st_mode = M_NAME;
            else if (data_byte == CH_MINUS)
            begin
                st_clr_float = 1'b1;
                st_mode      = M_NSIGN;
            end
            else if (is_digit(data_byte))
            begin
                st_clr_float = 1'b1;
                st_mode      = (data_byte == CH_ZERO) ? M_NZERO : M_NINT;
            end
            else if (data_byte == CH_QUOTE)
                st_mode = M_STR;
            else
            begin
                st_mode = M_ERR;
                st_emit = 1'b1;
                st_rec  = make_rec(RT_TOKEN, K_EOF, pos_reg, pos_reg, 8'd0, E_UNEXPECTED);
            end
        end
    end

    logic                     do_start;
    logic                     pre_emit;
    gtl_result_t              pre_rec;
    gtl_result_t              o0, o1;
    logic [1:0]               cnt;
    logic [8:0]               esc;
    logic [POSITION_BITS-1:0] p1;
    logic [4:0]               num_kind;

    always_comb
    begin
        mode_next      = mode_reg;
        tok_start_next = tok_start_reg;
        pos_next       = pos_reg;
        is_float_next  = is_float_reg;
        do_start       = 1'b0;
        pre_emit       = 1'b0;
        pre_rec        = '0;
        o0             = '0;
        o1             = '0;
        cnt            = 2'd0;
        esc            = unescape(data_byte);
        p1             = pos_inc(pos_reg);
        num_kind       = is_float_reg ? K_FLOAT : K_INT;

        if (end_of_query)
        begin
            // flush a pending token, then EOF, then back to reset state
            o0  = make_rec(RT_TOKEN, K_EOF, pos_reg, pos_reg, 8'd0, E_NONE);
            cnt = 2'd1;
            unique case (mode_reg)
                M_DOT1, M_DOT2:
                    pre_rec = make_rec(RT_TOKEN, K_EOF, tok_start_reg, pos_reg, 8'd0,
                                       E_UNEXPECTED);
                M_NAME:
                    pre_rec = make_rec(RT_TOKEN, K_NAME, tok_start_reg, pos_reg, 8'd0, E_NONE);
                M_NZERO, M_NINT, M_NFRAC, M_NEDIG:
                    pre_rec = make_rec(RT_TOKEN, num_kind, tok_start_reg, pos_reg, 8'd0,
                                       E_NONE);
                M_NSIGN, M_NDOT, M_NEXP, M_NESIGN:
                    pre_rec = make_rec(RT_TOKEN, K_EOF, tok_start_reg, pos_reg, 8'd0,
                                       E_EXP_DIGIT);
                M_STR, M_ESC:
                    pre_rec = make_rec(RT_TOKEN, K_EOF, tok_start_reg, pos_reg, 8'd0,
                                       E_UNTERMINATED);
                M_CMT:
                    pre_rec = make_rec(RT_TOKEN, K_COMMENT, tok_start_reg, pos_reg, 8'd0,
                                       E_NONE);
                M_IDLE, M_ERR:
                    pre_rec = '0;
            endcase
            if (mode_reg != M_IDLE && mode_reg != M_ERR)
            begin
                o1  = o0;
                o0  = pre_rec;
                cnt = 2'd2;
            end
            mode_next      = M_IDLE;
            tok_start_next = '0;
            pos_next       = '0;
            is_float_next  = 1'b0;
        end
        else
        begin
            pos_next = p1;
            unique case (mode_reg)
                M_IDLE:
                    do_start = 1'b1;
                M_DOT1:
                    if (data_byte == CH_DOT)
                        mode_next = M_DOT2;
                    else
                    begin
                        o0 = make_rec(RT_TOKEN, K_EOF, tok_start_reg, pos_reg, 8'd0,
                                      E_UNEXPECTED);
                        cnt = 2'd1;
                        mode_next = M_ERR;
                    end
                M_DOT2:
                    if (data_byte == CH_DOT)
                    begin
                        o0 = make_rec(RT_TOKEN, K_SPREAD, tok_start_reg, p1, 8'd0, E_NONE);
                        cnt = 2'd1;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        o0 = make_rec(RT_TOKEN, K_EOF, tok_start_reg, pos_reg, 8'd0,
                                      E_UNEXPECTED);
                        cnt = 2'd1;
                        mode_next = M_ERR;
                    end
                M_NAME:
                    if (!(is_alpha(data_byte) || is_digit(data_byte)))
                    begin
                        pre_emit = 1'b1;
                        pre_rec  = make_rec(RT_TOKEN, K_NAME, tok_start_reg, pos_reg, 8'd0,
                                            E_NONE);
                        do_start = 1'b1;
                    end
                M_NSIGN:
                    if (data_byte == CH_ZERO)
                        mode_next = M_NZERO;
                    else if (is_digit(data_byte))
                        mode_next = M_NINT;
                    else
                    begin
                        o0 = make_rec(RT_TOKEN, K_EOF, tok_start_reg, pos_reg, 8'd0,
                                      E_EXP_DIGIT);
                        cnt = 2'd1;
                        mode_next = M_ERR;
                    end
                M_NZERO, M_NINT:
                    if (is_digit(data_byte))
                    begin
                        if (mode_reg == M_NZERO)
                        begin
                            o0 = make_rec(RT_TOKEN, K_EOF, tok_start_reg, pos_reg, 8'd0,
                                          E_LEADING_ZERO);
                            cnt = 2'd1;
                            mode_next = M_ERR;
                        end
                    end
                    else if (data_byte == CH_DOT)
                    begin
                        is_float_next = 1'b1;
                        mode_next     = M_NDOT;
                    end
                    else if (data_byte == CH_LOW_E || data_byte == CH_UP_E)
                    begin
                        is_float_next = 1'b1;
                        mode_next     = M_NEXP;
                    end
                    else
                    begin
                        pre_emit = 1'b1;
                        pre_rec  = make_rec(RT_TOKEN, num_kind, tok_start_reg, pos_reg, 8'd0,
                                            E_NONE);
                        do_start = 1'b1;
                    end
                M_NDOT:
                    if (is_digit(data_byte))
                        mode_next = M_NFRAC;
                    else
                    begin
                        o0 = make_rec(RT_TOKEN, K_EOF, tok_start_reg, pos_reg, 8'd0,
                                      E_EXP_DIGIT);
                        cnt = 2'd1;
                        mode_next = M_ERR;
                    end
                M_NFRAC:
                    if (data_byte == CH_LOW_E || data_byte == CH_UP_E)
                        mode_next = M_NEXP;
                    else if (!is_digit(data_byte))
                    begin
                        pre_emit = 1'b1;
                        pre_rec  = make_rec(RT_TOKEN, num_kind, tok_start_reg, pos_reg, 8'd0,
                                            E_NONE);
                        do_start = 1'b1;
                    end
                M_NEXP:
                    if (data_byte == CH_PLUS || data_byte == CH_MINUS)
                        mode_next = M_NESIGN;
                    else if (is_digit(data_byte))
                        mode_next = M_NEDIG;
                    else
                    begin
                        o0 = make_rec(RT_TOKEN, K_EOF, tok_start_reg, pos_reg, 8'd0,
                                      E_EXP_DIGIT);
                        cnt = 2'd1;
                        mode_next = M_ERR;
                    end
                M_NESIGN:
                    if (is_digit(data_byte))
                        mode_next = M_NEDIG;
                    else
                    begin
                        o0 = make_rec(RT_TOKEN, K_EOF, tok_start_reg, pos_reg, 8'd0,
                                      E_EXP_DIGIT);
                        cnt = 2'd1;
                        mode_next = M_ERR;
                    end
                M_NEDIG:
                    if (!is_digit(data_byte))
                    begin
                        pre_emit = 1'b1;
                        pre_rec  = make_rec(RT_TOKEN, num_kind, tok_start_reg, pos_reg, 8'd0,
                                            E_NONE);
                        do_start = 1'b1;
                    end
                M_STR:
                    if (data_byte == CH_QUOTE)
                    begin
                        o0 = make_rec(RT_TOKEN, K_STRING, tok_start_reg, p1, 8'd0, E_NONE);
                        cnt = 2'd1;
                        mode_next = M_IDLE;
                    end
                    else if (data_byte == CH_LF || data_byte == CH_CR)
                    begin
                        o0 = make_rec(RT_TOKEN, K_EOF, tok_start_reg, pos_reg, 8'd0,
                                      E_UNTERMINATED);
                        cnt = 2'd1;
                        mode_next = M_ERR;
                    end
                    else if (data_byte < CH_SPACE && data_byte != CH_TAB)
                    begin
                        o0 = make_rec(RT_TOKEN, K_EOF, tok_start_reg, pos_reg, 8'd0,
                                      E_BAD_CHAR);
                        cnt = 2'd1;
                        mode_next = M_ERR;
                    end
                    else if (data_byte == CH_BSLASH)
                        mode_next = M_ESC;
                    else
                    begin
                        o0 = make_rec(RT_VALUE, K_STRING, tok_start_reg, p1, data_byte, E_NONE);
                        cnt = 2'd1;
                    end
                M_ESC:
                    if (!esc[8])
                    begin
                        o0 = make_rec(RT_TOKEN, K_EOF, tok_start_reg, pos_reg, 8'd0,
                                      E_BAD_ESCAPE);
                        cnt = 2'd1;
                        mode_next = M_ERR;
                    end
                    else
                    begin
                        o0 = make_rec(RT_VALUE, K_STRING, tok_start_reg, p1, esc[7:0], E_NONE);
                        cnt = 2'd1;
                        mode_next = M_STR;
                    end
                M_CMT:
                    if (data_byte == CH_LF || data_byte == CH_CR)
                    begin
                        o0 = make_rec(RT_TOKEN, K_COMMENT, tok_start_reg, pos_reg, 8'd0,
                                      E_NONE);
                        cnt = 2'd1;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        o0 = make_rec(RT_VALUE, K_COMMENT, tok_start_reg, p1, data_byte,
                                      E_NONE);
                        cnt = 2'd1;
                    end
                M_ERR:
                    mode_next = M_ERR;
            endcase

            // the byte that closes a name or number also opens the next token
            if (do_start)
            begin
                mode_next = st_mode;
                if (st_set_ts)
                    tok_start_next = pos_reg;
                if (st_clr_float)
                    is_float_next = 1'b0;
                if (pre_emit)
                begin
                    o0  = pre_rec;
                    o1  = st_rec;
                    cnt = st_emit ? 2'd2 : 2'd1;
                end
                else
                begin
                    o0  = st_rec;
                    cnt = st_emit ? 2'd1 : 2'd0;
                end
            end
        end

        if (cnt == 2'd2)
            o1.last_of_run = 1'b1;
        else if (cnt == 2'd1)
            o0.last_of_run = 1'b1;
    end

    assign res0      = o0;
    assign res1      = o1;
    assign res_count = cnt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_IDLE;
            tok_start_reg <= '0;
            pos_reg       <= '0;
            is_float_reg  <= 1'b0;
        end
        else if (step_en)
        begin
            mode_reg      <= mode_next;
            tok_start_reg <= tok_start_next;
            pos_reg       <= pos_next;
            is_float_reg  <= is_float_next;
        end
    end

    a_end_gives_eof: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && end_of_query |-> res_count != 2'd0)
        else $error("end marker produced no result");

    a_end_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && end_of_query |=> pos_reg == '0 && mode_reg == M_IDLE)
        else $error("end marker did not return lexer to reset state");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && !end_of_query && mode_reg == M_ERR |=> mode_reg == M_ERR)
        else $error("left error mode without end marker");

endmodule

// File: rtl/core/gtl_outq.sv
// small result queue: takes up to two results a cycle, hands out one
// depends on gtl_pkg
module gtl_outq
    import gtl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  push_count,
    input  gtl_result_t push0,
    input  gtl_result_t push1,
    input  logic        pop,
    output gtl_result_t head,
    output logic        not_empty,
    output logic        room2
);

    localparam int PtrW = $clog2(GTL_QUEUE_DEPTH);
    localparam int CntW = $clog2(GTL_QUEUE_DEPTH + 1);

    gtl_result_t       entry_reg [GTL_QUEUE_DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   count_reg, count_next;
    logic [PtrW-1:0]   wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign wr_ptr_next  = wr_ptr_reg + PtrW'(push_count);
    assign rd_ptr_next  = rd_ptr_reg + PtrW'(pop);
    assign count_next   = count_reg + CntW'(push_count) - CntW'(pop);

    assign head      = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign room2     = (count_reg <= CntW'(GTL_QUEUE_DEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            entry_reg[wr_ptr_reg] <= push0;
        if (push_count == 2'd2)
            entry_reg[wr_ptr_plus1] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(GTL_QUEUE_DEPTH))
        else $error("result queue overflow");

endmodule

// File: rtl/core/graphql_token_lexer.sv
// top level of the byte-serial query lexer: input register, lexer core, result queue
// depends on gtl_pkg, gtl_core, gtl_outq
//
//  channel | signals                          | direction | transfer when
//  query   | query_valid, data_byte,          | in        | query_valid && !query_stall
//          | end_of_query / query_stall       |           |
//  result  | result_valid, result_type ...    | out       | result_valid && !result_stall
//          | last_of_run / result_stall       |           |
//
// one query byte is taken every cycle while query_stall is low; a result passes the input
// register, then the result queue, before it is offered
// an item that yields two results hands them to the result port one at a time; a four-entry
// result queue absorbs this and the input stalls only when fewer than two slots are free
// reset clears lexer mode, positions and queue pointers; bytes are counted from zero again
// after each end marker
module graphql_token_lexer
    import gtl_pkg::*;
#(
    parameter int POSITION_BITS = GTL_POSITION_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        query_valid,
    output logic        query_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_query,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        result_type,
    output logic [4:0]  token_kind,
    output logic [15:0] start_pos,
    output logic [15:0] end_pos,
    output logic [7:0]  value_byte,
    output logic [2:0]  error_code,
    output logic        last_of_run
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_end_reg;
    logic        room2;
    logic        step_en;
    logic        not_empty;
    logic        pop;
    gtl_result_t res0, res1, head;
    logic [1:0]  res_count;
    logic [1:0]  push_count;

    assign step_en     = in_valid_reg && room2;
    assign query_stall = in_valid_reg && !room2;
    assign push_count  = step_en ? res_count : 2'd0;
    assign pop         = not_empty && !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!query_stall)
            in_valid_reg <= query_valid;
    end

    always_ff @(posedge clk)
    begin
        if (query_valid && !query_stall)
        begin
            in_byte_reg <= data_byte;
            in_end_reg  <= end_of_query;
        end
    end

    gtl_core #(
        .POSITION_BITS(POSITION_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (step_en),
        .data_byte   (in_byte_reg),
        .end_of_query(in_end_reg),
        .res0        (res0),
        .res1        (res1),
        .res_count   (res_count)
    );

    gtl_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_count(push_count),
        .push0     (res0),
        .push1     (res1),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .room2     (room2)
    );

    assign result_valid = not_empty;
    assign result_type  = head.result_type;
    assign token_kind   = head.token_kind;
    assign start_pos    = head.start_pos;
    assign end_pos      = head.end_pos;
    assign value_byte   = head.value_byte;
    assign error_code   = head.error_code;
    assign last_of_run  = head.last_of_run;

    a_valid_drops_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(result_valid) |-> !$past(result_stall))
        else $error("result dropped without a transfer");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        query_stall |-> in_valid_reg && !room2)
        else $error("input stalled with room in the result queue");

endmodule

// File: test/graphql_token_lexer_tb.sv
// testbench for graphql_token_lexer: directed rows, then random queries
// predicts every result with an in-bench lexer model; depends on gtl_pkg and the lexer rtl
`timescale 1ns / 1ps

module graphql_token_lexer_tb;
    import gtl_pkg::*;

    typedef enum logic [3:0]
    {
        LX_IDLE, LX_DOT1, LX_DOT2, LX_NAME, LX_NSIGN, LX_NZERO, LX_NINT, LX_NDOT,
        LX_NFRAC, LX_NEXP, LX_NESIGN, LX_NEDIG, LX_STR, LX_ESC, LX_CMT, LX_ERR
    } lex_mode_t;

    typedef struct packed {
        logic [7:0]  b;
        logic        eoq;
        logic        chk;
        logic [4:0]  kind;
        logic [2:0]  ec;
        logic [15:0] spos;
        logic [15:0] epos;
    } dir_row_t;

    localparam int DIR_ROWS = 25;

    // typed expectation applies to the last result of the row
    localparam dir_row_t DIRECTED [0:DIR_ROWS-1] = '{
        '{8'h00, 1'b1, 1'b1, K_EOF,     E_NONE,         16'd0, 16'd0},
        '{8'h7B, 1'b0, 1'b1, K_BRACE_L, E_NONE,         16'd0, 16'd1},
        '{8'h01, 1'b0, 1'b1, K_EOF,     E_CONTROL,      16'd1, 16'd1},
        '{8'hFF, 1'b0, 1'b0, K_EOF,     E_NONE,         16'd0, 16'd0},
        '{8'h00, 1'b1, 1'b1, K_EOF,     E_NONE,         16'd3, 16'd3},
        '{8'h30, 1'b0, 1'b0, K_EOF,     E_NONE,         16'd0, 16'd0},
        '{8'h31, 1'b0, 1'b1, K_EOF,     E_LEADING_ZERO, 16'd0, 16'd1},
        '{8'h00, 1'b1, 1'b1, K_EOF,     E_NONE,         16'd2, 16'd2},
        '{8'h2D, 1'b0, 1'b0, K_EOF,     E_NONE,         16'd0, 16'd0},
        '{8'h78, 1'b0, 1'b1, K_EOF,     E_EXP_DIGIT,    16'd0, 16'd1},
        '{8'h00, 1'b1, 1'b1, K_EOF,     E_NONE,         16'd2, 16'd2},
        '{8'h22, 1'b0, 1'b0, K_EOF,     E_NONE,         16'd0, 16'd0},
        '{8'h5C, 1'b0, 1'b0, K_EOF,     E_NONE,         16'd0, 16'd0},
        '{8'h75, 1'b0, 1'b1, K_EOF,     E_BAD_ESCAPE,   16'd0, 16'd2},
        '{8'h00, 1'b1, 1'b1, K_EOF,     E_NONE,         16'd3, 16'd3},
        '{8'h80, 1'b0, 1'b1, K_EOF,     E_UNEXPECTED,   16'd0, 16'd0},
        '{8'h00, 1'b1, 1'b1, K_EOF,     E_NONE,         16'd1, 16'd1},
        '{8'h2E, 1'b0, 1'b0, K_EOF,     E_NONE,         16'd0, 16'd0},
        '{8'h2E, 1'b0, 1'b0, K_EOF,     E_NONE,         16'd0, 16'd0},
        '{8'h2E, 1'b0, 1'b1, K_SPREAD,  E_NONE,         16'd0, 16'd3},
        '{8'h23, 1'b0, 1'b0, K_EOF,     E_NONE,         16'd0, 16'd0},
        '{8'h63, 1'b0, 1'b0, K_EOF,     E_NONE,         16'd0, 16'd0},
        '{8'h0A, 1'b0, 1'b1, K_COMMENT, E_NONE,         16'd3, 16'd5},
        '{8'h37, 1'b0, 1'b0, K_EOF,     E_NONE,         16'd0, 16'd0},
        '{8'h00, 1'b1, 1'b1, K_EOF,     E_NONE,         16'd7, 16'd7}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        query_valid = 1'b0;
    logic        query_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        end_of_query = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic        result_type;
    logic [4:0]  token_kind;
    logic [15:0] start_pos;
    logic [15:0] end_pos;
    logic [7:0]  value_byte;
    logic [2:0]  error_code;
    logic        last_of_run;

    graphql_token_lexer dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .query_valid  (query_valid),
        .query_stall  (query_stall),
        .data_byte    (data_byte),
        .end_of_query (end_of_query),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_type  (result_type),
        .token_kind   (token_kind),
        .start_pos    (start_pos),
        .end_pos      (end_pos),
        .value_byte   (value_byte),
        .error_code   (error_code),
        .last_of_run  (last_of_run)
    );

    always #5 clk = ~clk;

    // lexer model state
    lex_mode_t   lx_mode = LX_IDLE;
    logic [15:0] lx_tok_start = 16'd0;
    logic [15:0] lx_pos = 16'd0;
    logic        lx_is_float = 1'b0;
    gtl_result_t out_buf [0:1];
    int          out_n;

    gtl_result_t expected_tokens [$];
    int          mismatch_count = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          live_items = 0;
    logic [7:0]  gen_bytes [$];

    function automatic string fmt_result(input gtl_result_t r);
        return $sformatf("type=%0d kind=%0d start=%0d end=%0d val=%02h err=%0d last=%0d",
                         r.result_type, r.token_kind, r.start_pos, r.end_pos,
                         r.value_byte, r.error_code, r.last_of_run);
    endfunction

    function automatic void flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at %0t ns: %s", $time, msg);
    endfunction

    function automatic logic [15:0] pos_next(input logic [15:0] p);
        return (p == 16'hFFFF) ? p : p + 16'd1;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || (b == "_");
    endfunction

    function automatic logic is_exp_mark(input logic [7:0] b);
        return (b == CH_LOW_E) || (b == CH_UP_E);
    endfunction

    function automatic logic [4:0] punct_of(input logic [7:0] b);
        case (b)
            "!":     return K_BANG;
            "$":     return K_DOLLAR;
            "&":     return K_AMP;
            "(":     return K_PAREN_L;
            ")":     return K_PAREN_R;
            ":":     return K_COLON;
            "=":     return K_EQUALS;
            "@":     return K_AT;
            "[":     return K_BRACKET_L;
            "]":     return K_BRACKET_R;
            "{":     return K_BRACE_L;
            "|":     return K_PIPE;
            "}":     return K_BRACE_R;
            default: return K_EOF;
        endcase
    endfunction

    // bit 8 marks a known escape
    function automatic logic [8:0] escape_of(input logic [7:0] b);
        case (b)
            CH_QUOTE:  return {1'b1, CH_QUOTE};
            "/":       return {1'b1, 8'h2F};
            CH_BSLASH: return {1'b1, CH_BSLASH};
            "b":       return {1'b1, 8'h08};
            "f":       return {1'b1, 8'h0C};
            "n":       return {1'b1, CH_LF};
            "r":       return {1'b1, CH_CR};
            "t":       return {1'b1, CH_TAB};
            default:   return 9'd0;
        endcase
    endfunction

    function automatic void put_result(input logic t, input logic [4:0] k,
                                       input logic [15:0] s, input logic [15:0] e,
                                       input logic [7:0] v, input logic [2:0] ec);
        gtl_result_t r;
        if (out_n < 2)
        begin
            r.result_type = t;
            r.token_kind  = k;
            r.start_pos   = s;
            r.end_pos     = e;
            r.value_byte  = v;
            r.error_code  = ec;
            r.last_of_run = 1'b0;
            out_buf[out_n] = r;
            out_n++;
        end
    endfunction

    function automatic void lex_fail(input logic [2:0] ec, input logic [15:0] s,
                                     input logic [15:0] e);
        put_result(RT_TOKEN, K_EOF, s, e, 8'h00, ec);
        lx_mode = LX_ERR;
    endfunction

    function automatic void emit_number(input logic [15:0] p);
        put_result(RT_TOKEN, lx_is_float ? K_FLOAT : K_INT, lx_tok_start, p, 8'h00, E_NONE);
        lx_mode = LX_IDLE;
    endfunction

    // byte seen between tokens
    function automatic void lex_start(input logic [7:0] b, input logic [15:0] p);
        logic [4:0] k;
        lx_mode = LX_IDLE;
        k = punct_of(b);
        if (b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR || b == CH_COMMA)
            return;
        if (b < CH_SPACE)
        begin
            lex_fail(E_CONTROL, p, p);
            return;
        end
        lx_tok_start = p;
        if (k != K_EOF)
            put_result(RT_TOKEN, k, p, pos_next(p), 8'h00, E_NONE);
        else if (b == CH_DOT)
            lx_mode = LX_DOT1;
        else if (b == CH_HASH)
            lx_mode = LX_CMT;
        else if (is_alpha(b))
            lx_mode = LX_NAME;
        else if (b == CH_MINUS || is_digit(b))
        begin
            lx_is_float = 1'b0;
            lx_mode = (b == CH_MINUS) ? LX_NSIGN : (b == CH_ZERO) ? LX_NZERO : LX_NINT;
        end
        else if (b == CH_QUOTE)
            lx_mode = LX_STR;
        else
            lex_fail(E_UNEXPECTED, p, p);
    endfunction

    function automatic void lex_flush(input logic [15:0] p);
        case (lx_mode)
            LX_DOT1, LX_DOT2:
                put_result(RT_TOKEN, K_EOF, lx_tok_start, p, 8'h00, E_UNEXPECTED);
            LX_NAME:
                put_result(RT_TOKEN, K_NAME, lx_tok_start, p, 8'h00, E_NONE);
            LX_NZERO, LX_NINT, LX_NFRAC, LX_NEDIG:
                put_result(RT_TOKEN, lx_is_float ? K_FLOAT : K_INT, lx_tok_start, p,
                           8'h00, E_NONE);
            LX_NSIGN, LX_NDOT, LX_NEXP, LX_NESIGN:
                put_result(RT_TOKEN, K_EOF, lx_tok_start, p, 8'h00, E_EXP_DIGIT);
            LX_STR, LX_ESC:
                put_result(RT_TOKEN, K_EOF, lx_tok_start, p, 8'h00, E_UNTERMINATED);
            LX_CMT:
                put_result(RT_TOKEN, K_COMMENT, lx_tok_start, p, 8'h00, E_NONE);
            default:
                ;
        endcase
        put_result(RT_TOKEN, K_EOF, p, p, 8'h00, E_NONE);
        lx_mode      = LX_IDLE;
        lx_tok_start = 16'd0;
        lx_pos       = 16'd0;
        lx_is_float  = 1'b0;
    endfunction

    // advance the model by one accepted item and queue what it must produce
    task automatic lex_step(input logic [7:0] b, input logic eoq);
        logic [15:0] p;
        logic [8:0]  esc;
        p = lx_pos;
        out_n = 0;
        if (eoq)
            lex_flush(p);
        else
        begin
            case (lx_mode)
                LX_IDLE:
                    lex_start(b, p);
                LX_DOT1:
                    if (b == CH_DOT)
                        lx_mode = LX_DOT2;
                    else
                        lex_fail(E_UNEXPECTED, lx_tok_start, p);
                LX_DOT2:
                    if (b == CH_DOT)
                    begin
                        put_result(RT_TOKEN, K_SPREAD, lx_tok_start, pos_next(p), 8'h00, E_NONE);
                        lx_mode = LX_IDLE;
                    end
                    else
                        lex_fail(E_UNEXPECTED, lx_tok_start, p);
                LX_NAME:
                    if (!(is_alpha(b) || is_digit(b)))
                    begin
                        put_result(RT_TOKEN, K_NAME, lx_tok_start, p, 8'h00, E_NONE);
                        lex_start(b, p);
                    end
                LX_NSIGN:
                    if (b == CH_ZERO)
                        lx_mode = LX_NZERO;
                    else if (is_digit(b))
                        lx_mode = LX_NINT;
                    else
                        lex_fail(E_EXP_DIGIT, lx_tok_start, p);
                LX_NZERO, LX_NINT:
                    if (is_digit(b))
                    begin
                        if (lx_mode == LX_NZERO)
                            lex_fail(E_LEADING_ZERO, lx_tok_start, p);
                    end
                    else if (b == CH_DOT)
                    begin
                        lx_is_float = 1'b1;
                        lx_mode = LX_NDOT;
                    end
                    else if (is_exp_mark(b))
                    begin
                        lx_is_float = 1'b1;
                        lx_mode = LX_NEXP;
                    end
                    else
                    begin
                        emit_number(p);
                        lex_start(b, p);
                    end
                LX_NDOT:
                    if (is_digit(b))
                        lx_mode = LX_NFRAC;
                    else
                        lex_fail(E_EXP_DIGIT, lx_tok_start, p);
                LX_NFRAC:
                    if (is_exp_mark(b))
                        lx_mode = LX_NEXP;
                    else if (!is_digit(b))
                    begin
                        emit_number(p);
                        lex_start(b, p);
                    end
                LX_NEXP:
                    if (b == CH_PLUS || b == CH_MINUS)
                        lx_mode = LX_NESIGN;
                    else if (is_digit(b))
                        lx_mode = LX_NEDIG;
                    else
                        lex_fail(E_EXP_DIGIT, lx_tok_start, p);
                LX_NESIGN:
                    if (is_digit(b))
                        lx_mode = LX_NEDIG;
                    else
                        lex_fail(E_EXP_DIGIT, lx_tok_start, p);
                LX_NEDIG:
                    if (!is_digit(b))
                    begin
                        emit_number(p);
                        lex_start(b, p);
                    end
                LX_STR:
                    if (b == CH_QUOTE)
                    begin
                        put_result(RT_TOKEN, K_STRING, lx_tok_start, pos_next(p), 8'h00, E_NONE);
                        lx_mode = LX_IDLE;
                    end
                    else if (b == CH_LF || b == CH_CR)
                        lex_fail(E_UNTERMINATED, lx_tok_start, p);
                    else if (b < CH_SPACE && b != CH_TAB)
                        lex_fail(E_BAD_CHAR, lx_tok_start, p);
                    else if (b == CH_BSLASH)
                        lx_mode = LX_ESC;
                    else
                        put_result(RT_VALUE, K_STRING, lx_tok_start, pos_next(p), b, E_NONE);
                LX_ESC:
                begin
                    esc = escape_of(b);
                    if (!esc[8])
                        lex_fail(E_BAD_ESCAPE, lx_tok_start, p);
                    else
                    begin
                        put_result(RT_VALUE, K_STRING, lx_tok_start, pos_next(p), esc[7:0],
                                   E_NONE);
                        lx_mode = LX_STR;
                    end
                end
                LX_CMT:
                    if (b == CH_LF || b == CH_CR)
                    begin
                        put_result(RT_TOKEN, K_COMMENT, lx_tok_start, p, 8'h00, E_NONE);
                        lx_mode = LX_IDLE;
                    end
                    else
                        put_result(RT_VALUE, K_COMMENT, lx_tok_start, pos_next(p), b, E_NONE);
                default:
                    lx_mode = LX_ERR;
            endcase
            lx_pos = pos_next(p);
        end
        if (out_n > 0)
            out_buf[out_n-1].last_of_run = 1'b1;
        for (int i = 0; i < out_n; i++)
            expected_tokens.push_back(out_buf[i]);
    endtask

    // one transfer on the query channel; valid stays high across back-to-back items
    task automatic send_item(input logic [7:0] b, input logic eoq);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            query_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(posedge clk);
        end
        query_valid  <= 1'b1;
        data_byte    <= b;
        end_of_query <= eoq;
        @(posedge clk);
        while (query_stall)
            @(posedge clk);
        live_items++;
        lex_step(b, eoq);
    endtask

    function automatic logic [7:0] rand_alpha();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return 8'(r) + "a";
        else if (r < 52)
            return 8'(r - 26) + "A";
        return "_";
    endfunction

    function automatic logic [7:0] rand_digit(input int lo);
        return CH_ZERO + 8'($urandom_range(lo, 9));
    endfunction

    function automatic void push_int_part();
        if ($urandom_range(0, 3) == 0)
            gen_bytes.push_back(CH_MINUS);
        if ($urandom_range(0, 3) == 0)
            gen_bytes.push_back(CH_ZERO);
        else
        begin
            gen_bytes.push_back(rand_digit(1));
            repeat ($urandom_range(0, 4))
                gen_bytes.push_back(rand_digit(0));
        end
    endfunction

    function automatic void push_separator();
        int r;
        repeat ($urandom_range(1, 2))
        begin
            r = $urandom_range(0, 4);
            case (r)
                0:       gen_bytes.push_back(CH_SPACE);
                1:       gen_bytes.push_back(CH_TAB);
                2:       gen_bytes.push_back(CH_LF);
                3:       gen_bytes.push_back(CH_CR);
                default: gen_bytes.push_back(CH_COMMA);
            endcase
        end
    endfunction

    function automatic void push_token();
        localparam string PUNCTS = "!$&():=@[]{|}";
        localparam string ESCAPES = "\"/\\bfnrt";
        int          sel;
        int          form;
        logic [7:0]  c;
        sel = $urandom_range(0, 99);
        if (sel < 12)
            push_separator();
        else if (sel < 28)
            gen_bytes.push_back(PUNCTS[$urandom_range(0, PUNCTS.len() - 1)]);
        else if (sel < 33)
            repeat (3) gen_bytes.push_back(CH_DOT);
        else if (sel < 48)
        begin
            gen_bytes.push_back(rand_alpha());
            repeat ($urandom_range(0, 6))
                gen_bytes.push_back(($urandom_range(0, 2) == 0) ? rand_digit(0) : rand_alpha());
        end
        else if (sel < 58)
            push_int_part();
        else if (sel < 66)
        begin
            push_int_part();
            form = $urandom_range(0, 2);
            if (form != 1)
            begin
                gen_bytes.push_back(CH_DOT);
                repeat ($urandom_range(1, 3))
                    gen_bytes.push_back(rand_digit(0));
            end
            if (form != 0)
            begin
                gen_bytes.push_back($urandom_range(0, 1) ? CH_LOW_E : CH_UP_E);
                case ($urandom_range(0, 2))
                    0:       gen_bytes.push_back(CH_PLUS);
                    1:       gen_bytes.push_back(CH_MINUS);
                    default: ;
                endcase
                repeat ($urandom_range(1, 3))
                    gen_bytes.push_back(rand_digit(0));
            end
        end
        else if (sel < 78)
        begin
            gen_bytes.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 6))
            begin
                form = $urandom_range(0, 9);
                if (form < 5)
                begin
                    c = 8'($urandom_range(32'h20, 32'h7E));
                    gen_bytes.push_back((c == CH_QUOTE || c == CH_BSLASH) ? 8'h61 : c);
                end
                else if (form < 7)
                    gen_bytes.push_back(8'($urandom_range(32'h80, 32'hFF)));
                else if (form < 8)
                    gen_bytes.push_back(CH_TAB);
                else
                begin
                    gen_bytes.push_back(CH_BSLASH);
                    gen_bytes.push_back(ESCAPES[$urandom_range(0, ESCAPES.len() - 1)]);
                end
            end
            gen_bytes.push_back(CH_QUOTE);
        end
        else if (sel < 88)
        begin
            gen_bytes.push_back(CH_HASH);
            repeat ($urandom_range(0, 8))
            begin
                c = 8'($urandom_range(0, 255));
                gen_bytes.push_back((c == CH_LF || c == CH_CR) ? 8'h78 : c);
            end
            if ($urandom_range(0, 4) != 0)
                gen_bytes.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
        end
        else
        begin
            // noise and broken tokens
            case ($urandom_range(0, 9))
                0: gen_bytes.push_back(8'($urandom_range(0, 255)));
                1: begin gen_bytes.push_back(CH_DOT); gen_bytes.push_back(rand_alpha()); end
                2:
                begin
                    gen_bytes.push_back(CH_DOT);
                    gen_bytes.push_back(CH_DOT);
                    gen_bytes.push_back(8'($urandom_range(0, 255)));
                end
                3: begin gen_bytes.push_back(CH_MINUS); gen_bytes.push_back(rand_alpha()); end
                4: begin gen_bytes.push_back(CH_ZERO); gen_bytes.push_back(rand_digit(0)); end
                5:
                begin
                    gen_bytes.push_back(rand_digit(1));
                    gen_bytes.push_back(CH_DOT);
                    gen_bytes.push_back(rand_alpha());
                end
                6:
                begin
                    gen_bytes.push_back(rand_digit(1));
                    gen_bytes.push_back(CH_LOW_E);
                    if ($urandom_range(0, 1))
                        gen_bytes.push_back(CH_MINUS);
                    gen_bytes.push_back(rand_alpha());
                end
                7:
                begin
                    gen_bytes.push_back(CH_QUOTE);
                    gen_bytes.push_back(CH_BSLASH);
                    gen_bytes.push_back(8'($urandom_range(0, 255)));
                end
                8:
                begin
                    gen_bytes.push_back(CH_QUOTE);
                    gen_bytes.push_back(8'($urandom_range(0, 31)));
                end
                default:
                begin
                    gen_bytes.push_back(CH_QUOTE);
                    gen_bytes.push_back(rand_alpha());
                end
            endcase
        end
        if ($urandom_range(0, 9) < 6)
            push_separator();
    endfunction

    // result channel: check every transfer and stall at random
    always @(posedge clk)
    begin : result_check
        gtl_result_t seen;
        gtl_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            seen.result_type = result_type;
            seen.token_kind  = token_kind;
            seen.start_pos   = start_pos;
            seen.end_pos     = end_pos;
            seen.value_byte  = value_byte;
            seen.error_code  = error_code;
            seen.last_of_run = last_of_run;
            if (expected_tokens.size() == 0)
                flag_mismatch({"unexpected result ", fmt_result(seen)});
            else
            begin
                want = expected_tokens.pop_front();
                if (seen !== want)
                    flag_mismatch({"expected ", fmt_result(want), " got ", fmt_result(seen)});
            end
        end
        if (rst_n)
            result_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        dir_row_t row;
        int       phase_base;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = DIRECTED[i];
            send_item(row.b, row.eoq);
            if (row.chk)
            begin
                if (out_n == 0 || out_buf[out_n-1].token_kind !== row.kind ||
                    out_buf[out_n-1].error_code !== row.ec ||
                    out_buf[out_n-1].start_pos !== row.spos ||
                    out_buf[out_n-1].end_pos !== row.epos)
                    flag_mismatch($sformatf("directed row %0d: model disagrees with table", i));
            end
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 79; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 79; end
                default: begin send_idle_pct = 9;  stall_pct = 9;  end
            endcase
            phase_base = live_items;
            while (live_items - phase_base < 400)
            begin
                gen_bytes.delete();
                repeat ($urandom_range(1, 12))
                    push_token();
                foreach (gen_bytes[k])
                    send_item(gen_bytes[k], 1'b0);
                send_item(8'($urandom_range(0, 255)), 1'b1);
            end
        end
        query_valid <= 1'b0;

        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
